@@ rtl/process_priority_queue_macros.svh @@
// ----------------------------------------------------------------------------
// process priority queue assertion macros
// shared assertion forms for the queue checker
// ----------------------------------------------------------------------------
`ifndef PROCESS_PRIORITY_QUEUE_MACROS_SVH
`define PROCESS_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, disabled during reset
`define PPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ppq_pkg.sv @@
// ----------------------------------------------------------------------------
// ppq_pkg
// operation and status codes, defaults and cell control types of the
// process priority queue
// ----------------------------------------------------------------------------
package ppq_pkg;

    // default number of slots
    localparam int unsigned QUEUE_DEPTH_DEF = 16;

    // field widths
    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned PID_W    = 16;
    localparam int unsigned PRIO_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OCC_W    = 5;

    // operation codes
    localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] OP_POP    = 2'd1;
    localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic              search_pop; // 1: lowest priority search, 0: id match
        logic              ins_en;     // write the key into the tail slot
        logic              shift_en;   // close the gap at the shift index
        logic [PID_W-1:0]  key_pid;
        logic [PRIO_W-1:0] key_prio;
    } t_cell_ctrl;

    // search carry handed from one cell to the next
    typedef struct packed {
        logic              has;
        logic [PID_W-1:0]  pid;
        logic [PRIO_W-1:0] prio;
    } t_carry;

endpackage

@@ rtl/ppq_cell.sv @@
// ----------------------------------------------------------------------------
// ppq_cell
// one queue slot: holds an entry, takes part in the search carry chain and
// shifts forward from its upper neighbor when a gap is closed
// ----------------------------------------------------------------------------
module ppq_cell #(
    parameter int unsigned QUEUE_DEPTH = ppq_pkg::QUEUE_DEPTH_DEF,
    parameter int unsigned CELL_IDX    = 0,
    localparam int unsigned IW = $clog2(QUEUE_DEPTH),
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ppq_pkg::t_cell_ctrl          i_ctrl,
    input  logic [CW-1:0]                i_count,
    input  logic [IW-1:0]                i_shift_idx,
    input  logic [ppq_pkg::PID_W-1:0]    i_next_pid,
    input  logic [ppq_pkg::PRIO_W-1:0]   i_next_prio,
    input  ppq_pkg::t_carry              i_car,
    input  logic [IW-1:0]                i_car_idx,
    output logic [ppq_pkg::PID_W-1:0]    o_slot_pid,
    output logic [ppq_pkg::PRIO_W-1:0]   o_slot_prio,
    output ppq_pkg::t_carry              o_car,
    output logic [IW-1:0]                o_car_idx
);

    localparam logic [CW-1:0] MY_CNT = CW'(CELL_IDX);
    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    logic [ppq_pkg::PID_W-1:0]  r_pid;
    logic [ppq_pkg::PRIO_W-1:0] r_prio;
    ppq_pkg::t_carry            r_car;
    ppq_pkg::t_carry            n_car;
    logic [IW-1:0]              r_car_idx;
    logic [IW-1:0]              n_car_idx;
    logic                       w_valid;
    logic                       w_take;

    assign w_valid = (MY_CNT < i_count);

    // slot storage: tail write on insert, forward shift behind a removed entry
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins_en && (i_count == MY_CNT)) begin
            r_pid  <= i_ctrl.key_pid;
            r_prio <= i_ctrl.key_prio;
        end else if (i_ctrl.shift_en && (MY_IDX >= i_shift_idx)) begin
            r_pid  <= i_next_pid;
            r_prio <= i_next_prio;
        end
    end

    // search step: earliest strict minimum, or first id match
    always_comb begin
        if (i_ctrl.search_pop) begin
            w_take = w_valid && (!i_car.has || (r_prio < i_car.prio));
        end else begin
            w_take = w_valid && !i_car.has && (r_pid == i_ctrl.key_pid);
        end
        if (w_take) begin
            n_car.has  = 1'b1;
            n_car.pid  = r_pid;
            n_car.prio = r_prio;
            n_car_idx  = MY_IDX;
        end else begin
            n_car     = i_car;
            n_car_idx = i_car_idx;
        end
    end

    // carry register toward the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_car.has <= 1'b0;
        end else begin
            r_car.has <= n_car.has;
        end
        r_car.pid  <= n_car.pid;
        r_car.prio <= n_car.prio;
        r_car_idx  <= n_car_idx;
    end

    assign o_slot_pid  = r_pid;
    assign o_slot_prio = r_prio;
    assign o_car       = r_car;
    assign o_car_idx   = r_car_idx;

endmodule

@@ rtl/process_priority_queue.sv @@
// ----------------------------------------------------------------------------
// process_priority_queue
// bounded process queue in arrival order: insert at tail, pop lowest
// priority (earliest on ties), remove by id, built as a row of slot cells
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | i_func, i_entry_pid, i_entry_priority
//  out     | output    | o_out_valid / i_out_ready | o_status, o_out_pid, o_out_priority,
//          |           |                           | o_occupancy
//
// insert and unused codes go from the captured request straight to the apply
// step; pop and remove first pass through the scan state, with the search carry
// rippling one cell per cycle down the row of QUEUE_DEPTH cells.
// one item is worked on at a time; the next is taken once the result is
// loaded into the output register, even while that result waits.
// a stalled output holds the finished item in the apply step until it drains.
// reset clears the count and control; slot contents need no clearing.
// ----------------------------------------------------------------------------
module process_priority_queue #(
    parameter int unsigned QUEUE_DEPTH = ppq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [ppq_pkg::FUNC_W-1:0]     i_func,
    input  logic [ppq_pkg::PID_W-1:0]      i_entry_pid,
    input  logic [ppq_pkg::PRIO_W-1:0]     i_entry_priority,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [ppq_pkg::STATUS_W-1:0]   o_status,
    output logic [ppq_pkg::PID_W-1:0]      o_out_pid,
    output logic [ppq_pkg::PRIO_W-1:0]     o_out_priority,
    output logic [ppq_pkg::OCC_W-1:0]      o_occupancy
);

    localparam int unsigned IW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                       r_state;
    logic [1:0]                       n_state;
    logic [ppq_pkg::FUNC_W-1:0]       r_func;
    logic [ppq_pkg::PID_W-1:0]        r_pid;
    logic [ppq_pkg::PRIO_W-1:0]       r_prio;
    logic [IW-1:0]                    r_scan_cnt;
    logic [CW-1:0]                    r_count;
    logic [CW-1:0]                    n_count;

    logic                             r_out_valid;
    logic [ppq_pkg::STATUS_W-1:0]     r_status;
    logic [ppq_pkg::STATUS_W-1:0]     n_status;
    logic [ppq_pkg::PID_W-1:0]        r_out_pid;
    logic [ppq_pkg::PID_W-1:0]        n_out_pid;
    logic [ppq_pkg::PRIO_W-1:0]       r_out_prio;
    logic [ppq_pkg::PRIO_W-1:0]       n_out_prio;
    logic [CW-1:0]                    r_occ;

    logic                             w_in_xfer;
    logic                             w_apply;
    logic                             w_full;
    logic                             w_search_op;
    logic [CW+ppq_pkg::OCC_W-1:0]     w_occ_wide;
    ppq_pkg::t_cell_ctrl              w_ctrl;
    ppq_pkg::t_carry                  w_seed;
    ppq_pkg::t_carry                  w_result;

    logic [ppq_pkg::PID_W-1:0]        w_slot_pid  [QUEUE_DEPTH];
    logic [ppq_pkg::PRIO_W-1:0]       w_slot_prio [QUEUE_DEPTH];
    ppq_pkg::t_carry                  w_car       [QUEUE_DEPTH];
    logic [IW-1:0]                    w_car_idx   [QUEUE_DEPTH];

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_apply     = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign w_full      = (r_count == CW'(QUEUE_DEPTH));
    assign w_search_op = (i_func == ppq_pkg::OP_POP) || (i_func == ppq_pkg::OP_REMOVE);
    assign w_result    = w_car[QUEUE_DEPTH-1];

    // seed of the search chain: nothing found yet
    assign w_seed.has  = 1'b0;
    assign w_seed.pid  = '0;
    assign w_seed.prio = '0;

    // broadcast control to the cells
    always_comb begin
        w_ctrl.search_pop = (r_func == ppq_pkg::OP_POP);
        w_ctrl.key_pid    = r_pid;
        w_ctrl.key_prio   = r_prio;
        w_ctrl.ins_en     = w_apply && (r_func == ppq_pkg::OP_INSERT) && !w_full;
        w_ctrl.shift_en   = w_apply && w_result.has &&
                            ((r_func == ppq_pkg::OP_POP) || (r_func == ppq_pkg::OP_REMOVE));
    end

    // row of slot cells
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic [ppq_pkg::PID_W-1:0]  w_next_pid;
        logic [ppq_pkg::PRIO_W-1:0] w_next_prio;
        ppq_pkg::t_carry            w_car_in;
        logic [IW-1:0]              w_car_idx_in;

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_next_pid  = w_slot_pid[g];
            assign w_next_prio = w_slot_prio[g];
        end else begin : g_mid
            assign w_next_pid  = w_slot_pid[g+1];
            assign w_next_prio = w_slot_prio[g+1];
        end

        if (g == 0) begin : g_first
            assign w_car_in     = w_seed;
            assign w_car_idx_in = '0;
        end else begin : g_chain
            assign w_car_in     = w_car[g-1];
            assign w_car_idx_in = w_car_idx[g-1];
        end

        ppq_cell #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_count     (r_count),
            .i_shift_idx (w_car_idx[QUEUE_DEPTH-1]),
            .i_next_pid  (w_next_pid),
            .i_next_prio (w_next_prio),
            .i_car       (w_car_in),
            .i_car_idx   (w_car_idx_in),
            .o_slot_pid  (w_slot_pid[g]),
            .o_slot_prio (w_slot_prio[g]),
            .o_car       (w_car[g]),
            .o_car_idx   (w_car_idx[g])
        );
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = w_search_op ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (r_scan_cnt == IW'(QUEUE_DEPTH - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_apply) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result of the operation and new count
    always_comb begin
        n_status   = ppq_pkg::ST_OK;
        n_out_pid  = '0;
        n_out_prio = '0;
        n_count    = r_count;
        unique case (r_func)
            ppq_pkg::OP_INSERT: begin
                if (w_full) begin
                    n_status = ppq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            ppq_pkg::OP_POP: begin
                if (w_result.has) begin
                    n_out_pid  = w_result.pid;
                    n_out_prio = w_result.prio;
                    n_count    = r_count - CW'(1);
                end else begin
                    n_status = ppq_pkg::ST_EMPTY;
                end
            end
            ppq_pkg::OP_REMOVE: begin
                if (w_result.has) begin
                    n_count = r_count - CW'(1);
                end else begin
                    n_status = ppq_pkg::ST_NOTFOUND;
                end
            end
            default: begin
                n_status = ppq_pkg::ST_OK;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan_cnt  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SCAN) begin
                r_scan_cnt <= r_scan_cnt + IW'(1);
            end else begin
                r_scan_cnt <= '0;
            end
            if (w_apply) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // captured request
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_func <= i_func;
            r_pid  <= i_entry_pid;
            r_prio <= i_entry_priority;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_status   <= n_status;
            r_out_pid  <= n_out_pid;
            r_out_prio <= n_out_prio;
            r_occ      <= n_count;
        end
    end

    assign w_occ_wide     = {{ppq_pkg::OCC_W{1'b0}}, r_occ};
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_pid      = r_out_pid;
    assign o_out_priority = r_out_prio;
    assign o_occupancy    = w_occ_wide[ppq_pkg::OCC_W-1:0];

endmodule

@@ rtl/ppq_checker.sv @@
// ----------------------------------------------------------------------------
// ppq_checker
// port-level checks of the process priority queue, bound to the top level
// ----------------------------------------------------------------------------
`include "process_priority_queue_macros.svh"

module ppq_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_ready,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  logic [ppq_pkg::STATUS_W-1:0]   o_status,
    input  logic [ppq_pkg::PID_W-1:0]      o_out_pid,
    input  logic [ppq_pkg::PRIO_W-1:0]     o_out_priority,
    input  logic [ppq_pkg::OCC_W-1:0]      o_occupancy
);

    // a stalled result stays put
    `PPQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_status) && $stable(o_out_pid) &&
        $stable(o_out_priority) && $stable(o_occupancy), "stalled result changed")

    // one item at a time: busy right after a transfer in
    `PPQ_ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, i_in_valid && o_in_ready,
        !o_in_ready, "input taken while busy")

    // a failed operation carries no entry
    `PPQ_ASSERT_NOW(a_zero_on_fail, i_clk, i_rst_n, o_out_valid && (o_status != ppq_pkg::ST_OK),
        (o_out_pid == '0) && (o_out_priority == '0), "entry fields nonzero on failed operation")

    // an empty pop leaves nothing behind
    `PPQ_ASSERT_NOW(a_empty_occ, i_clk, i_rst_n,
        o_out_valid && (o_status == ppq_pkg::ST_EMPTY), o_occupancy == '0,
        "empty status with entries held")

endmodule

bind process_priority_queue ppq_checker u_ppq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status),
    .o_out_pid      (o_out_pid),
    .o_out_priority (o_out_priority),
    .o_occupancy    (o_occupancy)
);
